// ----- rtl/crfc_pkg.sv -----
// ----------------------------------------------------------------------------
// crfc_pkg
// types and constants shared by the credit rate feedback control unit
// ----------------------------------------------------------------------------
`default_nettype none

package crfc_pkg;

  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_ISSUE = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;
  localparam logic [1:0] OP_CLOSE = 2'd3;

  localparam logic [2:0] CFG_MAX_RATE    = 3'd0;
  localparam logic [2:0] CFG_TARGET_LOSS = 3'd1;
  localparam logic [2:0] CFG_MAX_LOSS    = 3'd2;
  localparam logic [2:0] CFG_WEIGHT_MAX  = 3'd3;
  localparam logic [2:0] CFG_WEIGHT_MIN  = 3'd4;

  localparam logic [31:0] MAX_RATE_RST    = 32'd1000000;
  localparam logic [15:0] TARGET_LOSS_RST = 16'd13107;
  localparam logic [15:0] MAX_LOSS_RST    = 16'd32768;
  localparam logic [15:0] WEIGHT_MAX_RST  = 16'd32768;
  localparam logic [15:0] WEIGHT_MIN_RST  = 16'd655;
  localparam logic [15:0] WEIGHT_RST      = 16'd4096;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic [31:0] max_rate;
    logic [15:0] target_loss;
    logic [15:0] max_loss;
    logic [15:0] weight_max;
    logic [15:0] weight_min;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        in_range;
    logic [3:0]  flow_index;
    logic [15:0] data_seq;
    logic [31:0] now_time;
    logic [31:0] rtt2;
  } item_t;

  typedef struct packed {
    logic [31:0] flow_rate;
    logic [15:0] credit_number;
    logic        flow_known;
    logic        feedback_done;
    logic [15:0] loss_ratio;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/crfc_req_if.sv -----
// ----------------------------------------------------------------------------
// crfc_req_if
// item channel into the credit rate feedback control unit
// ----------------------------------------------------------------------------
`default_nettype none

interface crfc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  flow_index;
  logic [15:0] data_seq;
  logic [31:0] sent_time;
  logic [31:0] now_time;

  modport source (output valid, opcode, flow_index, data_seq, sent_time, now_time,
                  input ready);
  modport sink (input valid, opcode, flow_index, data_seq, sent_time, now_time,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/crfc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// crfc_rsp_if
// result channel out of the credit rate feedback control unit
// ----------------------------------------------------------------------------
`default_nettype none

interface crfc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] flow_rate;
  logic [15:0] credit_number;
  logic        flow_known;
  logic        feedback_done;
  logic [15:0] loss_ratio;

  modport source (output valid, flow_rate, credit_number, flow_known, feedback_done,
                  loss_ratio, input ready);
  modport sink (input valid, flow_rate, credit_number, flow_known, feedback_done,
                loss_ratio, output ready);
endinterface

`default_nettype wire

// ----- rtl/crfc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// crfc_cfg_if
// register write channel
// ----------------------------------------------------------------------------
`default_nettype none

interface crfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/crfc_front.sv -----
// ----------------------------------------------------------------------------
// crfc_front
// accepts items, checks the slot range and precomputes the doubled delay
// ----------------------------------------------------------------------------
`default_nettype none

module crfc_front #(
  parameter int FLOW_SLOTS = 16
) (
  input  wire logic [1:0]     opcode,
  input  wire logic [3:0]     flow_index,
  input  wire logic [15:0]    data_seq,
  input  wire logic [31:0]    sent_time,
  input  wire logic [31:0]    now_time,
  output crfc_pkg::item_t     item
);
  import crfc_pkg::*;

  logic [31:0] delay;
  logic [32:0] delay2;

  always_comb begin
    delay           = now_time - sent_time;
    delay2          = {delay, 1'b0};
    item.opcode     = opcode;
    item.in_range   = (32'(flow_index) < 32'(FLOW_SLOTS));
    item.flow_index = flow_index;
    item.data_seq   = data_seq;
    item.now_time   = now_time;
    item.rtt2       = delay2[32] ? 32'hFFFF_FFFF : delay2[31:0];
  end

endmodule

`default_nettype wire

// ----- rtl/crfc_queue.sv -----
// ----------------------------------------------------------------------------
// crfc_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module crfc_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  crfc_pkg::item_t  push_item,
  output logic             full,
  input  wire logic        pop,
  output logic             not_empty,
  output crfc_pkg::item_t  head
);
  import crfc_pkg::*;

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/crfc_back.sv -----
// ----------------------------------------------------------------------------
// crfc_back
// per-flow state, loss ratio divider and rate update sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module crfc_back #(
  parameter int FLOW_SLOTS = 16,
  parameter int SEQ_BITS   = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  crfc_pkg::cfg_t     cfg,
  input  wire logic          q_valid,
  input  crfc_pkg::item_t    q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output crfc_pkg::result_t  out_res
);
  import crfc_pkg::*;

  localparam int SLOT_BITS = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int LW        = (SEQ_BITS + 1 > 17) ? SEQ_BITS + 1 : 17;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_FB0  = 4'd3;
  localparam logic [3:0] S_FB1  = 4'd4;
  localparam logic [3:0] S_FB2  = 4'd5;
  localparam logic [3:0] S_FB3  = 4'd6;
  localparam logic [3:0] S_FB4  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  typedef struct packed {
    logic [31:0]         rate;
    logic [SEQ_BITS-1:0] ccount;
    logic [SEQ_BITS-1:0] last_seq;
    logic [15:0]         pkts;
    logic [31:0]         rtt;
    logic [31:0]         lft;
  } row_t;

  row_t                  mem [FLOW_SLOTS];
  logic [FLOW_SLOTS-1:0] flow_valid;
  logic [3:0]            state;
  item_t                 cur;
  row_t                  row;
  logic                  known;
  result_t               res;
  logic [15:0]           weight;
  logic                  prev_inc;
  logic                  inc;
  logic [15:0]           lcap;
  logic [LW:0]           rem;
  logic [LW-1:0]         dvs;
  logic [15:0]           quo;
  logic [3:0]            step;
  logic [49:0]           prod;
  logic [49:0]           acc;
  logic [32:0]           boost;

  logic [SLOT_BITS-1:0]  addr;
  logic [SEQ_BITS-1:0]   seq_m;
  logic [31:0]           elapsed;
  logic [LW-1:0]         tot;
  logic [LW-1:0]         pk_w;
  logic                  fb_ok;
  logic [16:0]           gain;
  logic [32:0]           mul_a;
  logic [16:0]           mul_b;
  logic [LW:0]           rem2;
  logic [50:0]           sum;
  logic [31:0]           fb_rate;
  logic                  wr_en;
  row_t                  wr_row;
  logic                  set_valid;
  logic                  clr_valid;
  logic                  go_div;
  result_t               ex_res;

  assign addr    = SLOT_BITS'(cur.flow_index);
  assign seq_m   = SEQ_BITS'(cur.data_seq);
  assign elapsed = cur.now_time - row.lft;
  assign tot     = LW'(seq_m) - LW'(row.last_seq) + LW'(1);
  assign pk_w    = LW'(row.pkts);
  assign fb_ok   = (seq_m >= row.last_seq) && (tot >= pk_w);
  assign gain    = ONE_Q16 + 17'(cfg.target_loss);
  assign rem2    = {rem[LW-1:0], 1'b0};
  assign sum     = 51'(acc) + 51'(prod);
  assign q_pop   = (state == S_IDLE) && q_valid;

  always_comb begin
    unique case (state)
      S_FB1: begin
        mul_a = inc ? {1'b0, cfg.max_rate} : {1'b0, row.rate};
        mul_b = inc ? gain : ONE_Q16 - 17'(lcap);
      end
      S_FB2: begin
        mul_a = inc ? {1'b0, row.rate} : prod[48:16];
        mul_b = inc ? ONE_Q16 - 17'(weight) : gain;
      end
      default: begin
        mul_a = boost;
        mul_b = 17'(weight);
      end
    endcase
    if (state == S_FB3) begin
      fb_rate = (prod[49:48] != 2'b00) ? 32'hFFFF_FFFF : prod[47:16];
    end else begin
      fb_rate = (sum[50:48] != 3'b000) ? 32'hFFFF_FFFF : sum[47:16];
    end
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_row    = row;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    go_div    = 1'b0;
    ex_res    = '0;
    ex_res.flow_known = known;
    if (state == S_EXEC) begin
      if (cur.opcode == OP_OPEN && cur.in_range) begin
        wr_en           = 1'b1;
        set_valid       = 1'b1;
        wr_row.rate     = {5'd0, cfg.max_rate[31:5]};
        wr_row.ccount   = '0;
        wr_row.last_seq = '0;
        wr_row.pkts     = 16'd1;
        wr_row.rtt      = cur.rtt2;
        wr_row.lft      = cur.now_time;
        ex_res.flow_rate = {5'd0, cfg.max_rate[31:5]};
      end else if (known) begin
        ex_res.flow_rate = row.rate;
        unique case (cur.opcode)
          OP_ISSUE: begin
            ex_res.credit_number = 16'(row.ccount);
            wr_row.ccount = row.ccount + SEQ_BITS'(1);
            wr_en = 1'b1;
          end
          OP_DATA: begin
            if (seq_m < row.ccount) begin
              if (elapsed < row.rtt) begin
                if (row.pkts != 16'hFFFF) begin
                  wr_row.pkts = row.pkts + 16'd1;
                end
                wr_en = 1'b1;
              end else if (fb_ok) begin
                go_div = 1'b1;
              end else begin
                wr_row.last_seq = seq_m;
                wr_row.pkts     = 16'd1;
                wr_en           = 1'b1;
              end
            end
          end
          OP_CLOSE: begin
            clr_valid = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end else if ((state == S_FB3 && !inc) || state == S_FB4) begin
      wr_en           = 1'b1;
      wr_row.rate     = fb_rate;
      wr_row.rtt      = cur.rtt2;
      wr_row.lft      = cur.now_time;
      wr_row.last_seq = seq_m;
      wr_row.pkts     = 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_row;
    end
    if (q_pop) begin
      row <= mem[SLOT_BITS'(q_item.flow_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      flow_valid <= '0;
      weight     <= WEIGHT_RST;
      prev_inc   <= 1'b0;
      out_valid  <= 1'b0;
      known      <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (set_valid) begin
        flow_valid[addr] <= 1'b1;
      end
      if (clr_valid) begin
        flow_valid[addr] <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            known <= q_item.in_range && flow_valid[SLOT_BITS'(q_item.flow_index)];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res <= ex_res;
          if (go_div) begin
            dvs  <= tot;
            rem  <= (LW + 1)'(tot - pk_w);
            quo  <= 16'hFFFF;
            step <= 4'd15;
            if (tot - pk_w >= tot) begin
              state <= S_FB0;
            end else begin
              state <= S_DIV;
            end
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (rem2 >= {1'b0, dvs}) begin
            rem <= rem2 - {1'b0, dvs};
            quo <= {quo[14:0], 1'b1};
          end else begin
            rem <= rem2;
            quo <= {quo[14:0], 1'b0};
          end
          step <= step - 4'd1;
          if (step == 4'd0) begin
            state <= S_FB0;
          end
        end
        S_FB0: begin
          if (quo <= cfg.target_loss) begin
            inc <= 1'b1;
            if (prev_inc) begin
              weight <= 16'((17'(weight) + 17'(cfg.weight_max)) >> 1);
            end
            prev_inc <= 1'b1;
          end else begin
            inc      <= 1'b0;
            lcap     <= (quo <= cfg.max_loss) ? quo : cfg.max_loss;
            weight   <= ((weight >> 1) > cfg.weight_min) ? (weight >> 1) : cfg.weight_min;
            prev_inc <= 1'b0;
          end
          state <= S_FB1;
        end
        S_FB1: begin
          state <= S_FB2;
        end
        S_FB2: begin
          boost <= prod[48:16];
          state <= S_FB3;
        end
        S_FB3: begin
          acc <= prod;
          if (!inc) begin
            res.flow_rate     <= fb_rate;
            res.feedback_done <= 1'b1;
            res.loss_ratio    <= quo;
            state             <= S_OUT;
          end else begin
            state <= S_FB4;
          end
        end
        S_FB4: begin
          res.flow_rate     <= fb_rate;
          res.feedback_done <= 1'b1;
          res.loss_ratio    <= quo;
          state             <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/credit_rate_feedback_control_unit.sv -----
// ----------------------------------------------------------------------------
// credit_rate_feedback_control_unit
// receiver-side per-flow credit rate controller with loss based feedback
// ----------------------------------------------------------------------------
// Each item gives one result. Open, issue, close and data items that run no
// feedback pass the exec state on their way from queue head to the result
// register; a data item that ends a round trip also runs the 16-step loss
// ratio divider and the shared 33x17 multiplier for up to three products in
// a row, and leaves after state FB3 for a decrease or FB4 for an increase.
// A two-entry queue lets new items in while the back end works, and the result
// register lets the next item start while a result waits. Registers may be
// written only while no item is in flight.
`default_nettype none

module credit_rate_feedback_control_unit #(
  parameter int FLOW_SLOTS = 16,
  parameter int SEQ_BITS   = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  crfc_req_if.sink   req,
  crfc_rsp_if.source rsp,
  crfc_cfg_if.sink   cfg
);
  import crfc_pkg::*;

  cfg_t    regs;
  item_t   f_item;
  item_t   q_head;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  result_t res;

  assign cfg.ready = 1'b1;
  assign req.ready = ~q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_rate    <= MAX_RATE_RST;
      regs.target_loss <= TARGET_LOSS_RST;
      regs.max_loss    <= MAX_LOSS_RST;
      regs.weight_max  <= WEIGHT_MAX_RST;
      regs.weight_min  <= WEIGHT_MIN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MAX_RATE:    regs.max_rate    <= cfg.data;
        CFG_TARGET_LOSS: regs.target_loss <= cfg.data[15:0];
        CFG_MAX_LOSS:    regs.max_loss    <= cfg.data[15:0];
        CFG_WEIGHT_MAX:  regs.weight_max  <= cfg.data[15:0];
        CFG_WEIGHT_MIN:  regs.weight_min  <= cfg.data[15:0];
        default: begin
        end
      endcase
    end
  end

  crfc_front #(.FLOW_SLOTS(FLOW_SLOTS)) u_front (
    .opcode     (req.opcode),
    .flow_index (req.flow_index),
    .data_seq   (req.data_seq),
    .sent_time  (req.sent_time),
    .now_time   (req.now_time),
    .item       (f_item)
  );

  crfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req.valid & ~q_full),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  crfc_back #(.FLOW_SLOTS(FLOW_SLOTS), .SEQ_BITS(SEQ_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_res   (res)
  );

  assign rsp.flow_rate     = res.flow_rate;
  assign rsp.credit_number = res.credit_number;
  assign rsp.flow_known    = res.flow_known;
  assign rsp.feedback_done = res.feedback_done;
  assign rsp.loss_ratio    = res.loss_ratio;

endmodule

`default_nettype wire

// ----- sim/credit_rate_feedback_control_unit_tb.sv -----
// ----------------------------------------------------------------------------
// credit_rate_feedback_control_unit_tb
// self-checking bench for the per-flow credit rate controller: directed table
// with a few typed results, then random flow traffic under several register
// settings; typed results are checked as given, every other result against an
// in-bench model of the flow table
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module credit_rate_feedback_control_unit_tb;
  import crfc_pkg::*;

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [15:0] seq;
    logic [31:0] sent;
    logic [31:0] now;
    bit          typed;
    result_t     res;
  } row_t;

  logic clk;
  logic rst;

  crfc_req_if req_ch ();
  crfc_rsp_if rsp_ch ();
  crfc_cfg_if cfg_ch ();

  credit_rate_feedback_control_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // flow table model
  bit          fl_on [16];
  logic [31:0] fl_rate [16];
  logic [15:0] fl_credits [16];
  logic [15:0] fl_last_seq [16];
  logic [15:0] fl_pkts [16];
  logic [31:0] fl_rtt [16];
  logic [31:0] fl_mark [16];
  logic [15:0] shared_w;
  bit          was_raise;
  cfg_t        cfg_mirror;

  result_t     expected_results [$];
  bit          tag_typed;
  result_t     tag_res;
  int          errors;
  int          checked;
  int          feedbacks;
  int          settings;
  bit          idle_on;
  int          stall_left;
  logic [31:0] clock_t;
  row_t        rows [$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("timeout at %0t", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [31:0] double_rtt(logic [31:0] now, logic [31:0] sent);
    logic [31:0] d;
    logic [32:0] d2;
    d = now - sent;
    d2 = {d, 1'b0};
    return d2[32] ? 32'hFFFF_FFFF : d2[31:0];
  endfunction

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] adjust_rate(logic [31:0] rate, logic [15:0] loss);
    logic [63:0] gain, boost, sum, r;
    logic [16:0] avg;
    logic [15:0] l, half;
    gain = 64'd65536 + 64'(cfg_mirror.target_loss);
    if (loss <= cfg_mirror.target_loss) begin
      boost = (64'(cfg_mirror.max_rate) * gain) >> 16;
      if (was_raise) begin
        avg = {1'b0, shared_w} + {1'b0, cfg_mirror.weight_max};
        shared_w = avg[16:1];
      end
      sum = (64'd65536 - 64'(shared_w)) * 64'(rate) + 64'(shared_w) * boost;
      was_raise = 1'b1;
      return sat32(sum >> 16);
    end else begin
      l = (loss <= cfg_mirror.max_loss) ? loss : cfg_mirror.max_loss;
      r = (64'(rate) * (64'd65536 - 64'(l))) >> 16;
      half = shared_w >> 1;
      shared_w = (half > cfg_mirror.weight_min) ? half : cfg_mirror.weight_min;
      was_raise = 1'b0;
      return sat32((r * gain) >> 16);
    end
  endfunction

  function automatic result_t apply_item(logic [1:0] op, logic [3:0] s, logic [15:0] seq,
                                         logic [31:0] sent, logic [31:0] now);
    result_t     r;
    logic [31:0] el;
    longint      cnt, lost, tot;
    logic [63:0] q;
    r = '0;
    r.flow_known = fl_on[s];
    if (op == OP_OPEN) begin
      fl_on[s] = 1'b1;
      fl_rate[s] = cfg_mirror.max_rate >> 5;
      fl_credits[s] = '0;
      fl_last_seq[s] = '0;
      fl_pkts[s] = 16'd1;
      fl_rtt[s] = double_rtt(now, sent);
      fl_mark[s] = now;
      r.flow_rate = fl_rate[s];
    end else if (r.flow_known) begin
      if (op == OP_ISSUE) begin
        r.credit_number = fl_credits[s];
        fl_credits[s] = fl_credits[s] + 16'd1;
      end else if (op == OP_DATA && seq < fl_credits[s]) begin
        el = now - fl_mark[s];
        if (el < fl_rtt[s]) begin
          if (fl_pkts[s] != 16'hFFFF) fl_pkts[s] = fl_pkts[s] + 16'd1;
        end else begin
          cnt = longint'(fl_pkts[s]);
          lost = longint'(seq) - longint'(fl_last_seq[s]) + 1 - cnt;
          tot = lost + cnt;
          if (lost >= 0 && tot > 0) begin
            q = (64'(lost) << 16) / 64'(tot);
            r.loss_ratio = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
            r.feedback_done = 1'b1;
            fl_rate[s] = adjust_rate(fl_rate[s], r.loss_ratio);
            fl_rtt[s] = double_rtt(now, sent);
            fl_mark[s] = now;
          end
          fl_last_seq[s] = seq;
          fl_pkts[s] = 16'd1;
        end
      end
      r.flow_rate = fl_rate[s];
      if (op == OP_CLOSE) fl_on[s] = 1'b0;
    end
    return r;
  endfunction

  task automatic report(string field, longint unsigned e, longint unsigned a);
    $display("%0t mismatch %s expected %0d actual %0d", $time, field, e, a);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t r, e;
    if (rst) begin
      for (int i = 0; i < 16; i++) fl_on[i] = 1'b0;
      shared_w = WEIGHT_RST;
      was_raise = 1'b0;
      cfg_mirror = '{MAX_RATE_RST, TARGET_LOSS_RST, MAX_LOSS_RST, WEIGHT_MAX_RST,
                     WEIGHT_MIN_RST};
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_MAX_RATE:    cfg_mirror.max_rate = cfg_ch.data;
          CFG_TARGET_LOSS: cfg_mirror.target_loss = cfg_ch.data[15:0];
          CFG_MAX_LOSS:    cfg_mirror.max_loss = cfg_ch.data[15:0];
          CFG_WEIGHT_MAX:  cfg_mirror.weight_max = cfg_ch.data[15:0];
          CFG_WEIGHT_MIN:  cfg_mirror.weight_min = cfg_ch.data[15:0];
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        r = apply_item(req_ch.opcode, req_ch.flow_index, req_ch.data_seq,
                       req_ch.sent_time, req_ch.now_time);
        if (tag_typed) r = tag_res;
        expected_results.push_back(r);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result transaction rate %0d", $time, rsp_ch.flow_rate);
          errors++;
        end else begin
          e = expected_results.pop_front();
          checked++;
          if (rsp_ch.feedback_done) feedbacks++;
          if (rsp_ch.flow_rate !== e.flow_rate)
            report("flow_rate", e.flow_rate, rsp_ch.flow_rate);
          if (rsp_ch.credit_number !== e.credit_number)
            report("credit_number", e.credit_number, rsp_ch.credit_number);
          if (rsp_ch.flow_known !== e.flow_known)
            report("flow_known", e.flow_known, rsp_ch.flow_known);
          if (rsp_ch.feedback_done !== e.feedback_done)
            report("feedback_done", e.feedback_done, rsp_ch.feedback_done);
          if (rsp_ch.loss_ratio !== e.loss_ratio)
            report("loss_ratio", e.loss_ratio, rsp_ch.loss_ratio);
        end
      end
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (!idle_on) begin
      rsp_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      if ($urandom_range(0, 5) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 3);
    end
  end

  function automatic int pick_gap();
    if (!idle_on || $urandom_range(0, 2) != 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
  endfunction

  task automatic send_item(row_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= it.op;
    req_ch.flow_index <= it.slot;
    req_ch.data_seq <= it.seq;
    req_ch.sent_time <= it.sent;
    req_ch.now_time <= it.now;
    tag_typed <= it.typed;
    tag_res <= it.res;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] mr, logic [15:0] tl, logic [15:0] ml,
                           logic [15:0] wmax, logic [15:0] wmin);
    write_reg(CFG_MAX_RATE, mr);
    write_reg(CFG_TARGET_LOSS, {16'd0, tl});
    write_reg(CFG_MAX_LOSS, {16'd0, ml});
    write_reg(CFG_WEIGHT_MAX, {16'd0, wmax});
    write_reg(CFG_WEIGHT_MIN, {16'd0, wmin});
    cfg_ch.valid <= 1'b0;
    settings++;
  endtask

  function automatic row_t mk(logic [1:0] op, logic [3:0] s, logic [15:0] seq,
                              logic [31:0] sent, logic [31:0] now);
    row_t it;
    it.op = op;
    it.slot = s;
    it.seq = seq;
    it.sent = sent;
    it.now = now;
    it.typed = 1'b0;
    it.res = '0;
    return it;
  endfunction

  function automatic row_t mk_typed(logic [1:0] op, logic [3:0] s, logic [15:0] seq,
                                    logic [31:0] sent, logic [31:0] now, result_t res);
    row_t it;
    it = mk(op, s, seq, sent, now);
    it.typed = 1'b1;
    it.res = res;
    return it;
  endfunction

  function automatic row_t random_item();
    row_t        it;
    logic [3:0]  s;
    int          r;
    int          span;
    s = 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    clock_t += ($urandom_range(0, 7) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 20);
    if ($urandom_range(0, 49) == 0) clock_t = $urandom;
    it = mk(OP_DATA, s, 16'($urandom), clock_t - $urandom_range(0, 60), clock_t);
    if ($urandom_range(0, 19) == 0) it.sent = $urandom;
    if (!fl_on[s] && r < 70) it.op = OP_OPEN;
    else if (r < 8) it.op = OP_OPEN;
    else if (r < 45) it.op = OP_ISSUE;
    else if (r < 94) it.op = OP_DATA;
    else it.op = OP_CLOSE;
    if (it.op == OP_DATA && fl_credits[s] != 0 && $urandom_range(0, 99) < 85) begin
      span = (fl_credits[s] > 16'd4) ? 4 : int'(fl_credits[s]) - 1;
      it.seq = fl_credits[s] - 16'd1 - 16'($urandom_range(0, span));
    end
    return it;
  endfunction

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_OPEN;
    req_ch.flow_index = '0;
    req_ch.data_seq = '0;
    req_ch.sent_time = '0;
    req_ch.now_time = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MAX_RATE;
    cfg_ch.data = '0;
    tag_typed = 1'b0;
    tag_res = '0;
    errors = 0;
    checked = 0;
    feedbacks = 0;
    settings = 0;
    idle_on = 1'b1;
    clock_t = 32'd5000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table under reset settings
    rows.push_back(mk_typed(OP_DATA, 4'd0, 16'd0, 32'd0, 32'd10, '0));
    rows.push_back(mk_typed(OP_ISSUE, 4'd3, 16'd0, 32'd0, 32'd10, '0));
    rows.push_back(mk_typed(OP_CLOSE, 4'd5, 16'd0, 32'd0, 32'd10, '0));
    rows.push_back(mk_typed(OP_OPEN, 4'd0, 16'd0, 32'd100, 32'd150,
                            '{32'd31250, 16'd0, 1'b0, 1'b0, 16'd0}));
    rows.push_back(mk_typed(OP_ISSUE, 4'd0, 16'd0, 32'd0, 32'd151,
                            '{32'd31250, 16'd0, 1'b1, 1'b0, 16'd0}));
    repeat (3) rows.push_back(mk(OP_ISSUE, 4'd0, 16'd0, 32'd0, 32'd152));
    rows.push_back(mk(OP_DATA, 4'd0, 16'd0, 32'd155, 32'd160));
    rows.push_back(mk(OP_DATA, 4'd0, 16'd3, 32'd350, 32'd400));
    rows.push_back(mk(OP_DATA, 4'd0, 16'hFFFF, 32'd850, 32'd900));
    rows.push_back(mk(OP_OPEN, 4'd15, 16'd0, 32'hFFFF_FFF0, 32'h10));
    rows.push_back(mk(OP_OPEN, 4'd14, 16'd0, 32'd0, 32'hFFFF_FFFF));
    repeat (2) rows.push_back(mk(OP_ISSUE, 4'd15, 16'd0, 32'd0, 32'h11));
    rows.push_back(mk(OP_DATA, 4'd15, 16'd1, 32'h18, 32'h20));
    rows.push_back(mk(OP_DATA, 4'd15, 16'd1, 32'hFF0, 32'h1000));
    rows.push_back(mk(OP_ISSUE, 4'd15, 16'd0, 32'd0, 32'h1001));
    rows.push_back(mk(OP_DATA, 4'd15, 16'd2, 32'h1FF0, 32'h2000));
    rows.push_back(mk(OP_DATA, 4'd15, 16'd0, 32'h3FF0, 32'h4000));
    rows.push_back(mk_typed(OP_OPEN, 4'd0, 16'd0, 32'd1000, 32'd1010,
                            '{32'd31250, 16'd0, 1'b1, 1'b0, 16'd0}));
    rows.push_back(mk_typed(OP_CLOSE, 4'd0, 16'd0, 32'd0, 32'd1020,
                            '{32'd31250, 16'd0, 1'b1, 1'b0, 16'd0}));
    rows.push_back(mk(OP_CLOSE, 4'd14, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    foreach (rows[i]) send_item(rows[i]);
    drain();

    // random traffic across register settings, extremes first
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_all(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: write_all(32'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        2: write_all(MAX_RATE_RST, TARGET_LOSS_RST, MAX_LOSS_RST, WEIGHT_MAX_RST,
                     WEIGHT_MIN_RST);
        default: write_all($urandom_range(1, 32'hFFFF_FFFF), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom));
      endcase
      for (int k = 0; k < 500; k++) begin
        if (k % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
        send_item(random_item());
      end
      drain();
    end

    $display("%0d result transactions checked, %0d with rate feedback", checked, feedbacks);
    $display("%0d register settings, including both extremes", settings);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
